@@ rtl/rlp_header_decoder_core_defines.svh @@
// assertion macros used by the rlp header decoder rtl
`ifndef RLP_HEADER_DECODER_CORE_DEFINES_SVH
`define RLP_HEADER_DECODER_CORE_DEFINES_SVH

// plain property checked on every rising clock edge outside reset
`define RLPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define RLPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define RLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rlpd_pkg.sv @@
// types and constants of the rlp header decoder
package rlpd_pkg;

  localparam int unsigned MaxLengthBytesDefault = 4;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned OffsetW  = 32;
  localparam int unsigned LenW     = 24;
  localparam int unsigned HsizeW   = 3;
  localparam int unsigned LenSelW  = 4;
  localparam int unsigned BufLenW  = 32;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  // lead byte layout
  localparam logic [5:0] LenShortMax = 6'd55;
  localparam logic [2:0] HsizeMax    = 3'd7;

  // register index, taken from paddr[2]
  localparam logic RegIdxBufLen = 1'b0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERRUN  = 2'd1,
    ST_OVERFLOW = 2'd2
  } rlpd_status_e;

  typedef struct packed {
    logic [OffsetW-1:0] header_offset;
    logic [ByteW-1:0]   in_byte;
  } rlpd_item_t;

  typedef struct packed {
    logic               item_kind;
    logic [LenW-1:0]    payload_length;
    logic [HsizeW-1:0]  header_size;
    rlpd_status_e       status;
  } rlpd_result_t;

endpackage

@@ rtl/rlpd_cfg_regs.sv @@
// apb register file holding the buffer length
module rlpd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlpd_pkg::PaddrW-1:0]   paddr,
  input  logic [rlpd_pkg::PdataW-1:0]   pwdata,
  output logic [rlpd_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output logic [rlpd_pkg::BufLenW-1:0]  buf_len_o
);
  import rlpd_pkg::*;

  logic [BufLenW-1:0] buf_len_q, buf_len_d;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    buf_len_d = buf_len_q;
    if (wr_en && (paddr[2] == RegIdxBufLen)) begin
      buf_len_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= '0;
    end else begin
      buf_len_q <= buf_len_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegIdxBufLen) begin
      prdata = buf_len_q;
    end
  end

  assign buf_len_o = buf_len_q;

endmodule

@@ rtl/rlpd_hdr_decode.sv @@
// header decode state and single-pass result logic
module rlpd_hdr_decode #(
  parameter int unsigned MAX_LENGTH_BYTES = rlpd_pkg::MaxLengthBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  rlpd_pkg::rlpd_item_t          item_i,
  input  logic [rlpd_pkg::BufLenW-1:0]  buf_len_i,
  output logic                          res_valid_o,
  output rlpd_pkg::rlpd_result_t        res_o
);
  import rlpd_pkg::*;
  `include "rlp_header_decoder_core_defines.svh"

  localparam int unsigned CntW = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int unsigned HsW  = CntW + 1;
  localparam int unsigned SumW = OffsetW + 2;

  logic                coll_q, coll_d;
  logic [CntW-1:0]     left_q, left_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [LenW-1:0]     acc_q, acc_d;
  logic                ovf_q, ovf_d;
  logic [OffsetW-1:0]  off_q, off_d;
  logic                kind_q, kind_d;

  logic [ByteW-1:0]    b;
  logic [5:0]          v;
  logic                lead_kind;
  logic                is_short;
  logic [LenSelW-1:0]  n_bytes;
  logic                n_too_many;
  logic [LenW-1:0]     acc_nx;
  logic                ovf_nx;
  logic [CntW-1:0]     left_nx;
  logic [HsW-1:0]      hs_full;
  logic [31:0]         hs_wide;
  logic [HsizeW-1:0]   hs_sat;
  logic [OffsetW-1:0]  add_base;
  logic [LenSelW-1:0]  add_inc;
  logic [LenW-1:0]     add_len;
  logic [SumW-1:0]     end_sum;
  logic                overrun;
  logic                res_valid;
  rlpd_result_t        res;

  assign b          = item_i.in_byte;
  assign v          = b[5:0];
  assign lead_kind  = b[6];
  assign is_short   = (v <= LenShortMax);
  assign n_bytes    = LenSelW'(v - LenShortMax);
  assign n_too_many = (32'(n_bytes) > 32'(MAX_LENGTH_BYTES));

  // once the length passes 24 bits it is held and flagged
  assign ovf_nx  = ovf_q || (acc_q[LenW-1:LenW-8] != '0);
  assign acc_nx  = ovf_q ? acc_q : {acc_q[LenW-9:0], b};
  assign left_nx = (left_q != '0) ? left_q - CntW'(1) : '0;

  assign hs_full = HsW'(cnt_q) + HsW'(1);
  assign hs_wide = 32'(hs_full);
  assign hs_sat  = (hs_wide > 32'(HsizeMax)) ? HsizeMax : hs_wide[HsizeW-1:0];

  // one shared end-of-item adder: offset + 1 + extra header bytes + payload
  always_comb begin
    if (coll_q) begin
      add_base = off_q;
      add_inc  = LenSelW'(cnt_q);
      add_len  = acc_nx;
    end else begin
      add_base = item_i.header_offset;
      add_inc  = is_short ? '0 : n_bytes;
      add_len  = is_short ? LenW'(v) : '0;
    end
  end

  assign end_sum = SumW'(add_base) + SumW'(1) + SumW'(add_inc) + SumW'(add_len);
  assign overrun = (end_sum > SumW'(buf_len_i));

  always_comb begin
    coll_d    = coll_q;
    left_d    = left_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    off_d     = off_q;
    kind_d    = kind_q;
    res_valid = 1'b0;
    res       = '{item_kind: 1'b0, payload_length: '0, header_size: '0, status: ST_OK};

    if (coll_q) begin
      acc_d  = acc_nx;
      ovf_d  = ovf_nx;
      left_d = left_nx;
      if (left_nx == '0) begin
        coll_d    = 1'b0;
        res_valid = 1'b1;
        if (ovf_nx) begin
          res.status = ST_OVERFLOW;
        end else if (overrun) begin
          res.status = ST_OVERRUN;
        end else begin
          res.item_kind      = kind_q;
          res.payload_length = acc_nx;
          res.header_size    = hs_sat;
        end
      end
    end else begin
      res_valid = 1'b1;
      if (item_i.header_offset >= buf_len_i) begin
        res.status = ST_OVERRUN;
      end else if (!b[7]) begin
        res.payload_length = LenW'(1);
      end else if (is_short) begin
        if (overrun) begin
          res.status = ST_OVERRUN;
        end else begin
          res.item_kind      = lead_kind;
          res.payload_length = LenW'(v);
          res.header_size    = HsizeW'(1);
        end
      end else if (n_too_many) begin
        res.status = ST_OVERFLOW;
      end else if (overrun) begin
        res.status = ST_OVERRUN;
      end else begin
        // long form: collect the big-endian length bytes that follow
        res_valid = 1'b0;
        coll_d    = 1'b1;
        left_d    = CntW'(n_bytes);
        cnt_d     = CntW'(n_bytes);
        acc_d     = '0;
        ovf_d     = 1'b0;
        off_d     = item_i.header_offset;
        kind_d    = lead_kind;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q <= 1'b0;
      left_q <= '0;
      cnt_q  <= '0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      off_q  <= '0;
      kind_q <= 1'b0;
    end else if (fire_i) begin
      coll_q <= coll_d;
      left_q <= left_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      off_q  <= off_d;
      kind_q <= kind_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

  `RLPD_ASSERT_IMPL(a_err_zero, res_valid && (res.status != ST_OK),
    (res.item_kind == 1'b0) && (res.payload_length == '0) && (res.header_size == '0),
    "error result carries nonzero fields")
  `RLPD_ASSERT_IMPL(a_coll_left, coll_q, left_q != '0,
    "collecting with no length bytes left")
  `RLPD_ASSERT_IMPL(a_cnt_max, coll_q, 32'(cnt_q) <= 32'(MAX_LENGTH_BYTES),
    "length byte count above maximum")
  `RLPD_ASSERT_NEXT(a_start_coll, fire_i && !coll_q && !res_valid, coll_q,
    "silent lead byte did not start collection")

endmodule

@@ rtl/rlp_header_decoder_core.sv @@
// rlp header decoder top level: input register, decode, result register
//
// usage
//   s_axis carries one byte per transfer: tdata[7:0] in_byte, tdata[39:8]
//   header_offset (only read for lead bytes). m_axis carries one decoded
//   header per transfer: tdata payload_length, header_size, status,
//   tuser item_kind. the apb port holds buffer_length at address 0.
//   a lead byte gives a result at once unless it starts collecting length
//   bytes; then the result follows the last one and earlier bytes give none
// timing
//   one byte accepted per cycle, sustained while m_axis is not held; the
//   decode is one combinational pass between the input register and the
//   result register, and a header's result is decoded from its last byte
// reset
//   clears buffer_length, the valid flags of both pipeline registers and
//   the decode state; the block then waits for a lead byte
// stall
//   while m_axis is held, the result register and the input register stay
//   full and s_axis_tready drops; nothing is dropped or repeated
module rlp_header_decoder_core #(
  parameter int unsigned MAX_LENGTH_BYTES = rlpd_pkg::MaxLengthBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rlpd_pkg::InDataW-1:0]  s_axis_tdata,  // in_byte, header_offset
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rlpd_pkg::OutDataW-1:0] m_axis_tdata,  // payload_length, header_size, status
  output logic                          m_axis_tuser,  // item_kind
  // apb configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlpd_pkg::PaddrW-1:0]   paddr,
  input  logic [rlpd_pkg::PdataW-1:0]   pwdata,
  output logic [rlpd_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);
  import rlpd_pkg::*;

  logic               in_valid_q, in_valid_d;
  rlpd_item_t         in_item_q, in_item_d;
  logic               out_valid_q, out_valid_d;
  rlpd_result_t       out_res_q, out_res_d;
  logic               advance;
  logic               fire;
  logic               res_valid;
  rlpd_result_t       res;
  logic [BufLenW-1:0] buf_len;

  rlpd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .buf_len_o (buf_len)
  );

  rlpd_hdr_decode #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_item_q),
    .buf_len_i   (buf_len),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // the pipeline moves whenever the result register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    in_item_d  = in_item_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
      in_item_d  = s_axis_tdata;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (advance) begin
      out_valid_d = fire && res_valid;
    end
    if (fire && res_valid) begin
      out_res_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.item_kind;
  assign m_axis_tdata  = {3'b000, out_res_q.status, out_res_q.header_size,
                          out_res_q.payload_length};

endmodule

@@ sim/rlp_header_decoder_core_tb.sv @@
// testbench of the rlp header decoder: directed and random byte streams checked against a predictor
module rlp_header_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlpd_pkg::*;

  localparam int unsigned MaxLenBytes = MaxLengthBytesDefault;
  localparam logic [63:0] LenLimit   = 64'h00ff_ffff;
  localparam logic [PaddrW-1:0] BufLenAddr = {RegIdxBufLen, 2'b00};
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned IdlePct    = 23;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // in_byte, header_offset
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // payload_length, header_size, status
  logic                m_axis_tuser;   // item_kind
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  rlp_header_decoder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // decoder state as predicted
  logic [31:0]  buf_len;
  logic         dec_collecting;
  logic [2:0]   dec_left;
  logic [2:0]   dec_count;
  logic [31:0]  dec_acc;
  logic [31:0]  dec_off;
  logic         dec_kind;
  rlpd_result_t hdr_q[$];

  int unsigned fail_cnt;
  int unsigned sent_cnt;
  int unsigned hold_cycles;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[rlp_header_decoder_core] ERROR");
    $finish;
  end

  // receiver: random stalls, or a counted hold-off when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    rlpd_result_t exp_hdr;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hdr_q.size() == 0) begin
        fail_cnt++;
        $error("header result with none expected: tdata %h tuser %b", m_axis_tdata,
               m_axis_tuser);
      end else begin
        exp_hdr = hdr_q.pop_front();
        if (m_axis_tuser !== exp_hdr.item_kind) begin
          fail_cnt++;
          $error("item_kind: expected %0d, got %0d", exp_hdr.item_kind, m_axis_tuser);
        end
        if (m_axis_tdata[23:0] !== exp_hdr.payload_length) begin
          fail_cnt++;
          $error("payload_length: expected %0d, got %0d", exp_hdr.payload_length,
                 m_axis_tdata[23:0]);
        end
        if (m_axis_tdata[26:24] !== exp_hdr.header_size) begin
          fail_cnt++;
          $error("header_size: expected %0d, got %0d", exp_hdr.header_size,
                 m_axis_tdata[26:24]);
        end
        if (m_axis_tdata[28:27] !== exp_hdr.status) begin
          fail_cnt++;
          $error("status: expected %0d, got %0d", exp_hdr.status, m_axis_tdata[28:27]);
        end
      end
    end
  end

  function automatic void note_result(input logic kind, input logic [63:0] len,
                                      input logic [63:0] hsize, input rlpd_status_e st);
    rlpd_result_t r;
    if (st != ST_OK) begin
      kind  = 1'b0;
      len   = 64'd0;
      hsize = 64'd0;
    end
    r.item_kind      = kind;
    r.payload_length = len[23:0];
    r.header_size    = (hsize > 64'd7) ? HsizeMax : hsize[2:0];
    r.status         = st;
    hdr_q.push_back(r);
  endfunction

  // length limit first, then the exact (non-wrapping) end-of-payload check
  function automatic void close_header(input logic kind, input logic [63:0] off,
                                       input logic [63:0] hsize, input logic [63:0] len);
    if (len > LenLimit)
      note_result(1'b0, 64'd0, 64'd0, ST_OVERFLOW);
    else if (off + hsize + len > {32'd0, buf_len})
      note_result(1'b0, 64'd0, 64'd0, ST_OVERRUN);
    else
      note_result(kind, len, hsize, ST_OK);
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic [31:0] off);
    logic [5:0]  v;
    int unsigned n;
    v = b[5:0];
    n = (v > LenShortMax) ? int'(v) - int'(LenShortMax) : 0;
    if (dec_collecting) begin
      if ({32'd0, dec_acc} <= LenLimit) dec_acc = {dec_acc[23:0], b};
      if (dec_left != 3'd0) dec_left--;
      if (dec_left == 3'd0) begin
        dec_collecting = 1'b0;
        close_header(dec_kind, {32'd0, dec_off}, 64'(dec_count) + 64'd1, {32'd0, dec_acc});
      end
    end else if (off >= buf_len) begin
      note_result(1'b0, 64'd0, 64'd0, ST_OVERRUN);
    end else if (!b[7]) begin
      note_result(1'b0, 64'd1, 64'd0, ST_OK);
    end else if (v <= LenShortMax) begin
      close_header(b[6], {32'd0, off}, 64'd1, 64'(v));
    end else if (n > MaxLenBytes) begin
      note_result(1'b0, 64'd0, 64'd0, ST_OVERFLOW);
    end else if (64'(off) + 64'd1 + 64'(n) > 64'(buf_len)) begin
      note_result(1'b0, 64'd0, 64'd0, ST_OVERRUN);
    end else begin
      dec_collecting = 1'b1;
      dec_left       = 3'(n);
      dec_count      = 3'(n);
      dec_acc        = 32'd0;
      dec_off        = off;
      dec_kind       = b[6];
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic [31:0] off);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rlpd_item_t'{header_offset: off, in_byte: b};
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, off);
    sent_cnt++;
  endtask

  // drop valid and let every pending header come out
  task automatic wait_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (hdr_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_buf_len(input logic [31:0] val);
    wait_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BufLenAddr;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    buf_len = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== val) begin
      fail_cnt++;
      $error("buffer_length readback: expected %h, got %h", val, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // lead byte announcing n length bytes, then the length big-endian if collected
  task automatic send_long(input logic kind, input int unsigned n, input logic [31:0] len,
                           input logic [31:0] off);
    send_item({1'b1, kind, 6'(int'(LenShortMax) + n)}, off);
    if (dec_collecting)
      for (int i = int'(n) - 1; i >= 0; i--) send_item(len[8*i +: 8], $urandom());
  endtask

  task automatic flush_header();
    while (dec_collecting) send_item(8'($urandom_range(255)), $urandom());
  endtask

  function automatic logic [31:0] pick_offset();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return buf_len - 32'($urandom_range(1, 80));
    if (sel < 70) return 32'($urandom_range(0, 200));
    return $urandom();
  endfunction

  task automatic send_random_header();
    int unsigned  sel;
    int unsigned  n;
    logic         kind;
    logic [31:0]  off;
    logic [31:0]  len;
    logic [63:0]  room;
    flush_header();
    sel  = $urandom_range(99);
    kind = 1'($urandom_range(1));
    off  = pick_offset();
    n    = $urandom_range(1, MaxLenBytes);
    if (sel < 15) begin
      send_item(8'($urandom_range(0, 127)), off);
    end else if (sel < 40) begin
      send_item({1'b1, kind, 6'($urandom_range(0, 55))}, off);
    end else if (sel < 65) begin
      len = $urandom();
      if ($urandom_range(1) == 0) len[31:24] = 8'd0;
      if (n < 4) len = len & ((32'd1 << (8 * n)) - 32'd1);
      send_long(kind, n, len, off);
    end else if (sel < 88) begin
      // payload ending right at, or one past, the buffer end
      room = 64'(buf_len) - 64'(off) - 64'd1;
      len  = 32'(room) + 32'($urandom_range(0, 1));
      n    = (len > 32'h00ff_ffff) ? 4 : (len > 32'h0000_ffff) ? 3 : (len > 32'h00ff) ? 2 : 1;
      len  = len - 32'(n);
      send_long(kind, n, len, off);
    end else if (sel < 94) begin
      send_item({1'b1, kind, 6'(int'(LenShortMax) + $urandom_range(MaxLenBytes + 1, 8))}, off);
    end else begin
      // raw byte: may open a header whose length bytes come from the next random bytes
      send_item(8'($urandom_range(255)), off);
    end
  endtask

  task automatic run_random_phase(input logic [31:0] len_reg, input int unsigned upto);
    write_buf_len(len_reg);
    while (sent_cnt < upto) send_random_header();
    flush_header();
  endtask

  task automatic test_power_on();
    // buffer_length is zero out of reset, so every lead byte overruns
    send_item(8'h00, 32'd0);
    send_item(8'hc5, 32'h0000_1234);
  endtask

  task automatic test_short_items();
    write_buf_len(32'hffff_ffff);
    send_item(8'h00, 32'd0);
    send_item(8'h7f, 32'hffff_fffe);
    send_item(8'h80, 32'd5);
    send_item(8'hb7, 32'd100);
    send_item(8'hc0, 32'd7);
    send_item(8'hf7, 32'h8000_0000);
    send_item(8'h42, 32'hffff_ffff);
  endtask

  task automatic test_long_headers();
    send_long(1'b0, 1, 32'h0000_00ff, 32'd0);
    send_long(1'b1, 4, 32'h00ff_ffff, 32'd0);
    send_long(1'b0, 4, 32'h0100_0000, 32'd3);
    send_item(8'hbc, 32'd9);
    send_item(8'hff, 32'd9);
    // end of payload beyond 2^32: must not wrap
    send_long(1'b1, 2, 32'h0000_ffff, 32'hffff_fff0);
  endtask

  task automatic test_buffer_edges();
    write_buf_len(32'd10);
    send_item(8'h82, 32'd8);
    send_item(8'h81, 32'd8);
    send_item(8'h10, 32'd9);
    send_item(8'h10, 32'd10);
    send_long(1'b0, 3, 32'd0, 32'd8);
    send_long(1'b1, 3, 32'd0, 32'd6);
    send_long(1'b0, 3, 32'd1, 32'd6);
  endtask

  task automatic test_backpressure();
    write_buf_len(32'hffff_ffff);
    calm        = 1'b1;
    hold_cycles = 200;
    repeat (40) send_random_header();
    flush_header();
    calm = 1'b0;
    wait_results();
  endtask

  task automatic test_random_traffic();
    run_random_phase(32'hffff_ffff, 400);
    run_random_phase(32'd0, 450);
    run_random_phase(32'($urandom_range(16, 400)), 750);
    calm = 1'b1;
    run_random_phase(32'h0100_0004, 1000);
    calm = 1'b0;
    run_random_phase($urandom(), 1250);
    run_random_phase(32'hffff_ffff, 1550);
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    buf_len        = 32'd0;
    dec_collecting = 1'b0;
    dec_left       = 3'd0;
    dec_count      = 3'd0;
    dec_acc        = 32'd0;
    dec_off        = 32'd0;
    dec_kind       = 1'b0;
    fail_cnt       = 0;
    sent_cnt       = 0;
    hold_cycles    = 0;
    calm           = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_power_on();
    test_short_items();
    test_long_headers();
    test_buffer_edges();
    test_backpressure();
    test_random_traffic();

    wait_results();
    if (fail_cnt == 0) begin
      $display("[rlp_header_decoder_core] OK");
    end else begin
      $display("[rlp_header_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
